// ===== design/interval_overlap_max_counter_macros.svh =====
// Assertion macros used by the port checker.
`ifndef INTERVAL_OVERLAP_MAX_COUNTER_MACROS_SVH
`define INTERVAL_OVERLAP_MAX_COUNTER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define IOMC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IOMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/iomc_pkg.sv =====
`timescale 1ns / 1ps
package iomc_pkg;
    localparam int HEAP_CAPACITY = 1024;
    localparam int ADDR_W = $clog2(HEAP_CAPACITY);
    localparam int CNT_W = $clog2(HEAP_CAPACITY + 1);
    localparam int TIME_W = 31;
    localparam int OUT_W = 11;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Memory access request from the sequencer.
    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        time_t wr_data;
    } mem_req_t;
endpackage

// ===== design/interval_overlap_max_counter.sv =====
`timescale 1ns / 1ps
// Channel | Signals                                         | Direction
// in      | in_valid, in_stall, arrive/depart_time, last    | request in
// out     | out_valid, out_stall, occupancy, peak, ovf, done | result out
//
// From acceptance the walk pops each root departure earlier than the arrival
// (the last entry moves to the root and sifts down), then inserts the new
// departure at the tail and sifts it up; a full heap flags overflow instead.
// Reset is asynchronous: counters clear at once, heap RAM is never cleared.
// A result waits in an output register; the next request is taken only
// after the previous one finished its walk and the output is not stalled.
module interval_overlap_max_counter
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [30:0]          arrive_time,
    input  logic [30:0]          depart_time,
    input  logic                 last_interval,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [10:0]          occupancy,
    output logic [10:0]          peak_occupancy,
    output logic                 overflow,
    output logic                 set_done
);
    import iomc_pkg::*;

    mem_req_t req;
    time_t    rd_data;

    // Heap sequencer: pops, sift-down, insert and sift-up.
    iomc_seq u_seq
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .arrive_time(arrive_time), .depart_time(depart_time),
        .last_interval(last_interval),
        .out_valid(out_valid), .out_stall(out_stall),
        .occupancy(occupancy), .peak_occupancy(peak_occupancy),
        .overflow(overflow), .set_done(set_done),
        .req(req), .rd_data(rd_data)
    );

    // Heap store: one read port and one write port are enough.
    iomc_ram u_ram
    (
        .clk(clk), .req(req), .rd_data(rd_data)
    );
endmodule

// ===== design/iomc_ram.sv =====
`timescale 1ns / 1ps
module iomc_ram
(
    input  logic            clk,
    input  iomc_pkg::mem_req_t req,
    output iomc_pkg::time_t rd_data
);
    import iomc_pkg::*;

    time_t mem [HEAP_CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end
endmodule

// ===== design/iomc_seq.sv =====
`timescale 1ns / 1ps
module iomc_seq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  iomc_pkg::time_t    arrive_time,
    input  iomc_pkg::time_t    depart_time,
    input  logic               last_interval,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [10:0]        occupancy,
    output logic [10:0]        peak_occupancy,
    output logic               overflow,
    output logic               set_done,
    output iomc_pkg::mem_req_t req,
    input  iomc_pkg::time_t    rd_data
);
    import iomc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_TOP_RD, S_TOP_CHK, S_LAST_RD, S_LAST_WAIT,
        S_SINK_L, S_SINK_R, S_SINK_CMP, S_UP_RD, S_UP_CMP, S_DONE
    } state_t;

    state_t state_reg;
    time_t  arrive_reg, depart_reg, cur_reg, lc_reg;
    logic   last_reg, lc_ok_reg;
    cnt_t   count_reg, peak_reg;
    addr_t  pos_reg;
    logic   ovf_reg;
    logic   out_valid_reg;
    logic [OUT_W-1:0] occ_o_reg, peak_o_reg;
    logic   ovf_o_reg, done_o_reg;

    cnt_t  lc_w, rc_w;
    addr_t up_w;
    cnt_t  new_count;

    assign lc_w = cnt_t'({pos_reg, 1'b1});
    assign rc_w = cnt_t'({pos_reg, 1'b0}) + cnt_t'(2);
    assign up_w = addr_t'((pos_reg - addr_t'(1)) >> 1);
    assign new_count = count_reg + cnt_t'(1);

    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign occupancy = occ_o_reg;
    assign peak_occupancy = peak_o_reg;
    assign overflow = ovf_o_reg;
    assign set_done = done_o_reg;

    // Memory requests are decoded from state and registers.
    // Writes: each visited slot takes the entry that shifts into it; the moving value lands where the hole stops.
    always_comb
    begin
        req = '0;
        case (state_reg)
            S_TOP_RD:
            begin
                req.rd_en = 1'b1;
                req.rd_addr = '0;
            end
            S_LAST_RD:
            begin
                req.rd_en = 1'b1;
                req.rd_addr = addr_t'(count_reg);
            end
            S_SINK_L:
            begin
                req.rd_en = 1'b1;
                req.rd_addr = addr_t'(lc_w);
            end
            S_SINK_R:
            begin
                req.rd_en = 1'b1;
                req.rd_addr = addr_t'(rc_w);
            end
            S_UP_RD:
            begin
                req.rd_en = 1'b1;
                req.rd_addr = up_w;
            end
            default:
            begin
                req.rd_en = 1'b0;
            end
        endcase

        req.wr_addr = pos_reg;
        req.wr_data = cur_reg;
        case (state_reg)
            S_SINK_CMP:
            begin
                req.wr_en = 1'b1;
                if (rc_w < count_reg && rd_data < lc_reg && rd_data < cur_reg)
                begin
                    req.wr_data = rd_data;
                end
                else if (lc_ok_reg && lc_reg < cur_reg)
                begin
                    req.wr_data = lc_reg;
                end
                else
                begin
                    req.wr_data = cur_reg;
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    req.wr_en = 1'b1;
                    req.wr_data = depart_reg;
                end
            end
            S_UP_CMP:
            begin
                req.wr_en = 1'b1;
                req.wr_data = (depart_reg < rd_data) ? rd_data : depart_reg;
            end
            default:
            begin
                req.wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            peak_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // S_DONE sets the flag itself when it loads a new result
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        arrive_reg <= arrive_time;
                        depart_reg <= depart_time;
                        last_reg <= last_interval;
                        state_reg <= S_TOP_RD;
                    end
                end
                S_TOP_RD:
                begin
                    state_reg <= S_TOP_CHK;
                end
                S_TOP_CHK:
                begin
                    if (count_reg != '0 && rd_data < arrive_reg)
                    begin
                        count_reg <= count_reg - cnt_t'(1);
                        state_reg <= S_LAST_RD;
                    end
                    else if (count_reg == cnt_t'(HEAP_CAPACITY))
                    begin
                        ovf_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        // insert new departure at tail, then sift up
                        ovf_reg <= 1'b0;
                        pos_reg <= addr_t'(count_reg);
                        count_reg <= new_count;
                        if (new_count > peak_reg)
                        begin
                            peak_reg <= new_count;
                        end
                        state_reg <= S_UP_RD;
                    end
                end
                S_LAST_RD:
                begin
                    pos_reg <= '0;
                    state_reg <= S_LAST_WAIT;
                end
                S_LAST_WAIT:
                begin
                    cur_reg <= rd_data;
                    state_reg <= S_SINK_L;
                end
                S_SINK_L:
                begin
                    state_reg <= S_SINK_R;
                end
                S_SINK_R:
                begin
                    lc_reg <= rd_data;
                    lc_ok_reg <= lc_w < count_reg;
                    state_reg <= S_SINK_CMP;
                end
                S_SINK_CMP:
                begin
                    if (rc_w < count_reg && rd_data < lc_reg && rd_data < cur_reg)
                    begin
                        pos_reg <= addr_t'(rc_w);
                        state_reg <= S_SINK_L;
                    end
                    else if (lc_ok_reg && lc_reg < cur_reg)
                    begin
                        pos_reg <= addr_t'(lc_w);
                        state_reg <= S_SINK_L;
                    end
                    else
                    begin
                        state_reg <= S_TOP_RD;
                    end
                end
                S_UP_RD:
                begin
                    state_reg <= (pos_reg == '0) ? S_DONE : S_UP_CMP;
                end
                S_UP_CMP:
                begin
                    if (depart_reg < rd_data)
                    begin
                        pos_reg <= up_w;
                        state_reg <= S_UP_RD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        occ_o_reg <= OUT_W'(count_reg);
                        peak_o_reg <= OUT_W'(peak_reg);
                        ovf_o_reg <= ovf_reg;
                        done_o_reg <= last_reg;
                        if (last_reg)
                        begin
                            count_reg <= '0;
                            peak_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== design/iomc_checker.sv =====
`timescale 1ns / 1ps
`include "interval_overlap_max_counter_macros.svh"
module iomc_port_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [10:0] occupancy,
    input logic [10:0] peak_occupancy,
    input logic        overflow
);
    import iomc_pkg::*;

    `IOMC_ASSERT_IMPL(a_peak_ge, clk, rst_n, out_valid,
        peak_occupancy >= occupancy, "peak below occupancy")
    `IOMC_ASSERT_IMPL(a_ovf_full, clk, rst_n, out_valid && overflow,
        occupancy == OUT_W'(HEAP_CAPACITY), "overflow without full heap")
    `IOMC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(occupancy), "stalled result changed")
    `IOMC_ASSERT_IMPL(a_nonzero, clk, rst_n, out_valid,
        occupancy != 11'd0, "empty after insert")
endmodule

bind interval_overlap_max_counter iomc_port_checker u_chk
(
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_valid), .out_stall(out_stall), .occupancy(occupancy),
    .peak_occupancy(peak_occupancy), .overflow(overflow)
);

// ===== test/iomc_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels, models the min-heap occupancy scheme, compares results.
module iomc_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [30:0] arrive_time,
    input  logic [30:0] depart_time,
    input  logic        last_interval,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [10:0] occupancy,
    input  logic [10:0] peak_occupancy,
    input  logic        overflow,
    input  logic        set_done,
    output int          fail_count,
    output int          pending_count
);
    import iomc_pkg::*;

    typedef struct packed {
        logic [10:0] occ;
        logic [10:0] peak;
        logic        ovf;
        logic        done;
    } occ_result_t;

    time_t       departs [HEAP_CAPACITY];
    int          held;
    int          peak_held;
    occ_result_t expected_q [$];

    function automatic void heap_swap(int a, int b);
        time_t t;
        t = departs[a];
        departs[a] = departs[b];
        departs[b] = t;
    endfunction

    function automatic void pop_earliest();
        int pos;
        int best;
        held--;
        departs[0] = departs[held];
        pos = 0;
        forever
        begin
            best = pos;
            if (2*pos+1 < held && departs[2*pos+1] < departs[best]) best = 2*pos+1;
            if (2*pos+2 < held && departs[2*pos+2] < departs[best]) best = 2*pos+2;
            if (best == pos) break;
            heap_swap(pos, best);
            pos = best;
        end
    endfunction

    function automatic occ_result_t predict_occupancy(time_t arr, time_t dep, logic last);
        occ_result_t r;
        int pos;
        r.ovf = 1'b0;
        while (held > 0 && departs[0] < arr) pop_earliest();
        if (held < HEAP_CAPACITY)
        begin
            departs[held] = dep;
            pos = held;
            while (pos > 0 && departs[pos] < departs[(pos-1)/2])
            begin
                heap_swap(pos, (pos-1)/2);
                pos = (pos-1)/2;
            end
            held++;
        end
        else
            r.ovf = 1'b1;
        if (held > peak_held) peak_held = held;
        r.occ  = held[10:0];
        r.peak = peak_held[10:0];
        r.done = last;
        if (last)
        begin
            held = 0;
            peak_held = 0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        occ_result_t e;
        if (!rst_n)
        begin
            held          = 0;
            peak_held     = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_q.push_back(predict_occupancy(arrive_time, depart_time,
                                                       last_interval));
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with none expected: occ %0d peak %0d",
                             $time, occupancy, peak_occupancy);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e != {occupancy, peak_occupancy, overflow, set_done})
                    begin
                        $display("%0t: expected occ %0d peak %0d ovf %0b done %0b,",
                                 $time, e.occ, e.peak, e.ovf, e.done,
                                 " got occ %0d peak %0d ovf %0b done %0b",
                                 occupancy, peak_occupancy, overflow, set_done);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= expected_q.size();
        end
    end
endmodule

// ===== test/tb_interval_overlap_max_counter.sv =====
`timescale 1ns / 1ps
// Top: drives interval requests, stalls the result side, gives the verdict.
module tb_interval_overlap_max_counter;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [30:0] arrive_time = '0;
    logic [30:0] depart_time = '0;
    logic        last_interval = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [10:0] occupancy;
    logic [10:0] peak_occupancy;
    logic        overflow;
    logic        set_done;
    int          fail_count;
    int          pending_count;

    // idle percentages, changed per phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;       // long receiver hold-off for back pressure

    // running arrival clock for well-formed sets
    logic [30:0] now_t = '0;

    always #6 clk = ~clk;

    interval_overlap_max_counter i_dut (.*);

    iomc_checker i_check (.*);

    // Receiver stall, random per cycle or forced during a hold-off.
    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);

    // Offer one request and hold it until accepted. Sender gaps come before.
    task automatic send_interval(input logic [30:0] arr, input logic [30:0] dep,
                                 input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        arrive_time   <= arr;
        depart_time   <= dep;
        last_interval <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // A well-formed set: nondecreasing arrivals, random durations.
    task automatic send_set(input int n, input int max_dur);
        logic [30:0] d;
        for (int k = 0; k < n; k++)
        begin
            now_t = now_t + 31'($urandom_range(max_dur / 2));
            d = now_t + 31'($urandom_range(max_dur));
            if (d < now_t) d = 31'h7fffffff;
            send_interval(now_t, d, k == n - 1);
        end
        if (now_t > 31'h70000000) now_t = '0;
    endtask

    task automatic run_phase(input int sets);
        int r;
        for (int s = 0; s < sets; s++)
        begin
            r = $urandom_range(99);
            if (r < 85)
                send_set($urandom_range(1, 16), $urandom_range(1, 64));
            else
                // noise: raw random times, not ordered
                send_interval(31'($urandom), 31'($urandom), 1'($urandom_range(1)));
        end
        go_idle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, equal times, stray order, end of set.
        send_interval('0, '0, 1'b0);
        send_interval('0, '0, 1'b0);            // equal departure stays
        send_interval(31'd1, 31'd5, 1'b0);      // pops both zeros
        send_interval(31'd5, 31'd5, 1'b0);      // equal, not removed
        send_interval(31'd6, 31'h7fffffff, 1'b1);
        send_interval(31'h7fffffff, 31'h7fffffff, 1'b0);
        send_interval(31'h7fffffff, '0, 1'b1);
        send_interval(31'h2aaaaaaa, 31'h55555555, 1'b0);
        send_interval(31'h55555555, 31'h2aaaaaaa, 1'b1);
        // Fill to capacity plus overflow, then drain with one late arrival.
        for (int k = 0; k < 1026; k++)
            send_interval(31'd100, 31'd1000 + 31'($urandom_range(500)), 1'b0);
        send_interval(31'd1600, 31'd1700, 1'b1);
        go_idle();

        // Random phases: none, sender idle, receiver stall, both.
        send_idle_pct = 0;  recv_stall_pct = 0;  run_phase(40);
        send_idle_pct = 80; recv_stall_pct = 0;  run_phase(15);
        send_idle_pct = 0;  recv_stall_pct = 80; run_phase(15);
        send_idle_pct = 14; recv_stall_pct = 14; run_phase(25);

        // Back pressure: receiver holds off while the sender keeps offering.
        send_idle_pct = 0;  recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            send_set(16, 40);
        join
        go_idle();

        while (pending_count != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("status: fail");
        $finish;
    end
endmodule
